// ===== rtl/core/fdct_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frame DCT package
// Shared widths, cosine tables, gain constants and the interface types
// between the frame sequencer and the multiply-accumulate unit.
// ----------------------------------------------------------------------------
package fdct_pkg;

  localparam int FRAME_LEN = 32;
  localparam int MAX_OUT   = 32;
  localparam int OUT_LIMIT = (FRAME_LEN < MAX_OUT) ? FRAME_LEN : MAX_OUT;

  localparam int SAMPLE_W = 16;
  localparam int COEFF_W  = 24;
  localparam int INDEX_W  = 5;
  localparam int TYPE_W   = 2;
  localparam int COUNT_W  = 6;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 6;
  localparam int ADDR_W   = $clog2(FRAME_LEN);

  localparam int CV_W    = 17;
  localparam int GAIN_W  = 17;
  localparam int PROD_W  = SAMPLE_W + CV_W;
  localparam int ACC_W   = PROD_W + $clog2(FRAME_LEN);
  localparam int FRAC_SH = 15;

  localparam int COS1_DEN = FRAME_LEN - 1;
  localparam int COS2_DEN = 2 * FRAME_LEN;
  localparam int COS1_LEN = 2 * COS1_DEN;
  localparam int COS2_LEN = 2 * COS2_DEN;
  localparam int COS1_W   = $clog2(COS1_LEN);
  localparam int COS2_W   = $clog2(COS2_LEN);
  localparam int PHASE_W  = COS2_W;

  localparam logic [CFG_AW-1:0] REG_TYPE  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_SCALE = 2'd1;
  localparam logic [CFG_AW-1:0] REG_COUNT = 2'd2;

  localparam logic [TYPE_W-1:0] TYPE_DCT1   = 2'd0;
  localparam logic [TYPE_W-1:0] TYPE_DCT2   = 2'd1;
  localparam logic [TYPE_W-1:0] TYPE_OCTAVE = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int SQRT_HALF_Q15 = 23170;
  localparam longint unsigned SERIES_DIV [10] =
    '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

  localparam logic signed [CV_W-1:0] COS_ONE = 17'sd32768;

  typedef logic signed [CV_W-1:0] cos_t;
  typedef cos_t cos1_tab_t [COS1_LEN];
  typedef cos_t cos2_tab_t [COS2_LEN];

  // Cosine of pi*r/q in Q15 by a folded Taylor series; q is selected by tab2.
  function automatic cos_t cos_q15(input logic tab2, input int unsigned r_in);
    longint unsigned r;
    longint unsigned q;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sum;
    logic neg;
    q   = tab2 ? COS2_DEN : COS1_DEN;
    r   = r_in;
    neg = 1'b0;
    if (r > q) begin
      r = 2 * q - r;
    end
    if (2 * r > q) begin
      r   = q - r;
      neg = 1'b1;
    end
    if (tab2) begin
      x = (r * PI_Q30 + COS2_DEN / 2) / COS2_DEN;
    end else begin
      x = (r * PI_Q30 + COS1_DEN / 2) / COS1_DEN;
    end
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = 64'd1 << 30;
    sum  = longint'(term);
    for (int n = 0; n < 10; n++) begin
      term = (term * x2) / SERIES_DIV[n];
      term = term >> 30;
      if ((n & 1) == 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 16384) >>> 15;
    if (sum > 32768) begin
      sum = 32768;
    end
    if (neg) begin
      sum = -sum;
    end
    return CV_W'(sum);
  endfunction

  function automatic cos1_tab_t build_cos1();
    cos1_tab_t t;
    for (int r = 0; r < COS1_LEN; r++) begin
      t[r] = cos_q15(1'b0, r);
    end
    return t;
  endfunction

  function automatic cos2_tab_t build_cos2();
    cos2_tab_t t;
    for (int r = 0; r < COS2_LEN; r++) begin
      t[r] = cos_q15(1'b1, r);
    end
    return t;
  endfunction

  function automatic longint unsigned isqrt64(input longint unsigned v_in);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) begin
      b = b >> 2;
    end
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic int unsigned dc_gain(input int unsigned norm);
    return (norm * SQRT_HALF_Q15 + 8192) >> 14;
  endfunction

  localparam cos1_tab_t COS1_TAB = build_cos1();
  localparam cos2_tab_t COS2_TAB = build_cos2();

  localparam int unsigned NORM_PLAIN = 32768;
  localparam int unsigned NORM_SC_I  =
    int'((isqrt64((64'd1 << 33) / COS1_DEN) + 64'd1) >> 1);
  localparam int unsigned NORM_SC_II =
    int'((isqrt64((64'd1 << 33) / FRAME_LEN) + 64'd1) >> 1);

  localparam logic [GAIN_W-1:0] G_FULL_PLAIN = GAIN_W'(2 * NORM_PLAIN);
  localparam logic [GAIN_W-1:0] G_HALF_PLAIN = GAIN_W'(NORM_PLAIN);
  localparam logic [GAIN_W-1:0] G_DC_PLAIN   = GAIN_W'(dc_gain(NORM_PLAIN));
  localparam logic [GAIN_W-1:0] G_FULL_I     = GAIN_W'(2 * NORM_SC_I);
  localparam logic [GAIN_W-1:0] G_HALF_I     = GAIN_W'(NORM_SC_I);
  localparam logic [GAIN_W-1:0] G_FULL_II    = GAIN_W'(2 * NORM_SC_II);
  localparam logic [GAIN_W-1:0] G_DC_II      = GAIN_W'(dc_gain(NORM_SC_II));

  typedef struct packed {
    logic               vld;
    logic               first;
    logic               last;
    logic               tab2;
    logic               dc;
    logic [PHASE_W-1:0] phase;
    logic [GAIN_W-1:0]  gain;
  } fdct_mac_ctl_t;

  typedef struct packed {
    logic                      vld;
    logic signed [COEFF_W-1:0] coeff;
  } fdct_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/fdct_mac.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frame DCT multiply-accumulate unit
// Looks up the cosine, applies the gain, multiplies by the frame word and
// accumulates one coefficient; holds the saturated result until taken.
// ----------------------------------------------------------------------------
module fdct_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fdct_pkg::fdct_mac_ctl_t              ctl_i,
  input  logic signed [fdct_pkg::SAMPLE_W-1:0] x_i,
  input  logic                                 take_i,
  output fdct_pkg::fdct_res_t                  res_o
);
  import fdct_pkg::*;

  localparam int MPROD_W = CV_W + GAIN_W + 1;
  localparam logic signed [MPROD_W-1:0] M_ROUND = MPROD_W'(32768);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-8388608);

  logic                       a_vld_q, b_vld_q, c_vld_q, res_vld_q;
  logic                       a_first_q, a_last_q, b_first_q, b_last_q, c_first_q, c_last_q;
  logic signed [CV_W-1:0]     a_cv_q;
  logic [GAIN_W-1:0]          a_g_q;
  logic signed [CV_W-1:0]     b_m_q;
  logic signed [SAMPLE_W-1:0] b_x_q;
  logic signed [PROD_W-1:0]   c_prod_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;

  logic signed [CV_W-1:0]     cv_d;
  logic signed [MPROD_W-1:0]  mprod, mround;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    shifted;

  always_comb begin
    if (ctl_i.dc) begin
      cv_d = COS_ONE;
    end else if (ctl_i.tab2) begin
      cv_d = COS2_TAB[ctl_i.phase[COS2_W-1:0]];
    end else begin
      cv_d = COS1_TAB[ctl_i.phase[COS1_W-1:0]];
    end
  end

  assign mprod  = a_cv_q * $signed({1'b0, a_g_q});
  assign mround = mprod + M_ROUND;
  assign prod   = b_x_q * b_m_q;

  always_comb begin
    if (c_first_q) begin
      acc_d = ACC_W'(c_prod_q);
    end else begin
      acc_d = acc_q + ACC_W'(c_prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      a_vld_q <= ctl_i.vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      if (c_vld_q && c_last_q) begin
        res_vld_q <= 1'b1;
      end else if (take_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    a_first_q <= ctl_i.first;
    a_last_q  <= ctl_i.last;
    a_cv_q    <= cv_d;
    a_g_q     <= ctl_i.gain;
    b_first_q <= a_first_q;
    b_last_q  <= a_last_q && a_vld_q;
    b_m_q     <= mround[CV_W+15:16];
    b_x_q     <= x_i;
    c_first_q <= b_first_q;
    c_last_q  <= b_last_q;
    c_prod_q  <= prod;
    if (c_vld_q) begin
      acc_q <= acc_d;
    end
  end

  assign shifted = acc_q >>> FRAC_SH;

  always_comb begin
    res_o.vld = res_vld_q;
    if (shifted > SAT_HI) begin
      res_o.coeff = SAT_HI[COEFF_W-1:0];
    end else if (shifted < SAT_LO) begin
      res_o.coeff = SAT_LO[COEFF_W-1:0];
    end else begin
      res_o.coeff = shifted[COEFF_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/frame_dct_matrix_transform.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Frame DCT matrix transform
// Collects a frame of Q1.15 samples and emits its DCT-I, DCT-II or octave
// coefficients, saturated to 24 bits.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle, unless stalled, into a frame memory until
// FRAME_LEN words are held. The last word of a frame starts emission if the
// coefficient count is nonzero; during emission the input is stalled. Each
// coefficient reads all FRAME_LEN words of the frame memory into a single
// multiply-accumulate unit and, after its pipeline, is handed to the output
// register. The next coefficient is computed while the previous one waits in
// the output register. Configuration registers are read during emission and
// should be written only while the block is idle.
// ----------------------------------------------------------------------------
module frame_dct_matrix_transform (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fdct_pkg::CFG_AW-1:0]          cfg_addr_i,
  input  logic [fdct_pkg::CFG_DW-1:0]          cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [fdct_pkg::SAMPLE_W-1:0] sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [fdct_pkg::COEFF_W-1:0]  coeff_o,
  output logic [fdct_pkg::INDEX_W-1:0]         coeff_index_o,
  output logic                                 last_coeff_o
);
  import fdct_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_e;

  state_e                     state_q;
  logic [TYPE_W-1:0]          type_q;
  logic                       scale_q;
  logic [COUNT_W-1:0]         count_cfg_q;
  logic [ADDR_W-1:0]          fill_q;
  logic [ADDR_W-1:0]          idx_q;
  logic [INDEX_W-1:0]         k_q;
  logic [PHASE_W-1:0]         phase_q;
  logic                       out_valid_q;
  logic signed [COEFF_W-1:0]  coeff_q;
  logic [INDEX_W-1:0]         coeff_index_q;
  logic                       last_coeff_q;

  logic signed [SAMPLE_W-1:0] frame_mem [FRAME_LEN];
  logic signed [SAMPLE_W-1:0] rdata_q;

  logic                       in_acc;
  logic                       tab2, octave;
  logic [COUNT_W-1:0]         count;
  logic                       k_last;
  logic [INDEX_W-1:0]         k_next;
  logic [PHASE_W-1:0]         phase_init;
  logic [PHASE_W-1:0]         step;
  logic [PHASE_W:0]           phase_sum, phase_mod, phase_wrap;
  logic [GAIN_W-1:0]          gain;
  logic                       take;
  fdct_mac_ctl_t              ctl;
  fdct_res_t                  res;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign tab2   = (type_q != TYPE_DCT1);
  assign octave = (type_q == TYPE_OCTAVE);
  assign count  = (count_cfg_q > COUNT_W'(OUT_LIMIT)) ? COUNT_W'(OUT_LIMIT) : count_cfg_q;
  assign k_last = ({1'b0, k_q} == count - COUNT_W'(1));
  assign k_next = k_q + INDEX_W'(1);

  assign phase_init = tab2 ? PHASE_W'(k_next) : '0;
  assign step       = tab2 ? PHASE_W'({k_q, 1'b0}) : PHASE_W'(k_q);
  assign phase_sum  = {1'b0, phase_q} + {1'b0, step};
  assign phase_mod  = tab2 ? (PHASE_W + 1)'(COS2_LEN) : (PHASE_W + 1)'(COS1_LEN);
  assign phase_wrap = (phase_sum >= phase_mod) ? phase_sum - phase_mod : phase_sum;

  always_comb begin
    if (!tab2) begin
      if (k_q == '0 || int'(k_q) == FRAME_LEN - 1) begin
        gain = scale_q ? G_HALF_I : G_HALF_PLAIN;
      end else begin
        gain = scale_q ? G_FULL_I : G_FULL_PLAIN;
      end
    end else if (octave && k_q == '0) begin
      gain = scale_q ? G_DC_II : G_DC_PLAIN;
    end else begin
      gain = scale_q ? G_FULL_II : G_FULL_PLAIN;
    end
  end

  always_comb begin
    ctl.vld   = (state_q == ST_RUN);
    ctl.first = (idx_q == '0);
    ctl.last  = (idx_q == ADDR_W'(FRAME_LEN - 1));
    ctl.tab2  = tab2;
    ctl.dc    = octave && (k_q == '0);
    ctl.phase = phase_q;
    ctl.gain  = gain;
  end

  assign take = (state_q == ST_WAIT) && res.vld && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      frame_mem[fill_q] <= sample_i;
    end
    if (state_q == ST_RUN) begin
      rdata_q <= frame_mem[idx_q];
    end
  end

  fdct_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .x_i    (rdata_q),
    .take_i (take),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      type_q        <= TYPE_DCT2;
      scale_q       <= 1'b0;
      count_cfg_q   <= COUNT_RESET;
      fill_q        <= '0;
      idx_q         <= '0;
      k_q           <= '0;
      phase_q       <= '0;
      out_valid_q   <= 1'b0;
      coeff_q       <= '0;
      coeff_index_q <= '0;
      last_coeff_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_TYPE:  type_q      <= cfg_wdata_i[TYPE_W-1:0];
          REG_SCALE: scale_q     <= cfg_wdata_i[0];
          REG_COUNT: count_cfg_q <= cfg_wdata_i[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && !take) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (fill_q == ADDR_W'(FRAME_LEN - 1)) begin
              fill_q <= '0;
              if (count != '0) begin
                state_q <= ST_RUN;
                idx_q   <= '0;
                k_q     <= '0;
                phase_q <= '0;
              end
            end else begin
              fill_q <= fill_q + ADDR_W'(1);
            end
          end
        end
        ST_RUN: begin
          phase_q <= phase_wrap[PHASE_W-1:0];
          if (idx_q == ADDR_W'(FRAME_LEN - 1)) begin
            state_q <= ST_WAIT;
          end else begin
            idx_q <= idx_q + ADDR_W'(1);
          end
        end
        ST_WAIT: begin
          if (take) begin
            out_valid_q   <= 1'b1;
            coeff_q       <= res.coeff;
            coeff_index_q <= k_q;
            last_coeff_q  <= k_last;
            if (k_last) begin
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_RUN;
              k_q     <= k_next;
              idx_q   <= '0;
              phase_q <= phase_init;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign coeff_o       = coeff_q;
  assign coeff_index_o = coeff_index_q;
  assign last_coeff_o  = last_coeff_q;

endmodule
`default_nettype wire
